### hw/rtl/fixed_slot_pool_allocator_macros.svh
// Assertion macros shared by the slot pool allocator RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSPA_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("fspa assertion failed: same-cycle check");

// next-cycle implication, checked outside reset
`define FSPA_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("fspa assertion failed: next-cycle check");

`endif

### hw/rtl/fspa_pkg.sv
// Package for the slot pool allocator: sizes, operation codes, word types.
// No dependencies; imported by the controller, datapath and top allocator modules.
package fspa_pkg;

   localparam int SLOTS        = 1024;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int LINK_W       = $clog2(SLOTS + 1);
   localparam int SLOT_FIELD_W = 10;
   localparam int OP_W         = 2;

   localparam logic [OP_W-1:0] OP_GET     = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

   localparam logic [LINK_W-1:0] EMPTY_HEAD = LINK_W'(SLOTS);

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [SLOT_FIELD_W-1:0] slot_in;
   } req_word_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot_out;
      logic                    ok;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic pop_start;
      logic pop_finish;
   } dp_cmd_type;

   typedef struct packed {
      logic head_empty;
   } dp_status_type;

endpackage

### hw/rtl/fspa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module fspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/fspa_ctrl.sv
// Controller for the slot pool allocator: sequencing and result handshake.
// Depends on fspa_pkg and fixed_slot_pool_allocator_macros.svh.
`include "fixed_slot_pool_allocator_macros.svh"
module fspa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [fspa_pkg::OP_W-1:0] req_operation,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  fspa_pkg::dp_status_type status,
   output fspa_pkg::dp_cmd_type   cmd
);
   import fspa_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_POP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      accept;
   logic      pop_start;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign pop_start = accept && (req_operation == OP_GET) && !status.head_empty;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_start) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign cmd.accept     = accept;
   assign cmd.pop_start  = pop_start;
   assign cmd.pop_finish = (state_ff == S_POP);

   `FSPA_ASSERT_NOW(a_no_accept_in_pop, clock, reset, state_ff == S_POP, !cmd.accept)
   `FSPA_ASSERT_NEXT(a_pop_finishes, clock, reset, cmd.pop_start, cmd.pop_finish)
   `FSPA_ASSERT_NEXT(a_accept_gives_word, clock, reset, cmd.accept, rsp_valid)

endmodule

### hw/rtl/fspa_dp.sv
// Datapath for the slot pool allocator: free-list head, bump counter,
// next-link RAM and result register. Depends on fspa_pkg, fspa_ram, macros.
`include "fixed_slot_pool_allocator_macros.svh"
module fspa_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  fspa_pkg::req_word_type req_data,
   input  fspa_pkg::dp_cmd_type   cmd,
   output fspa_pkg::dp_status_type status,
   output fspa_pkg::rsp_word_type rsp_data
);
   import fspa_pkg::*;

   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic [LINK_W-1:0] bump_ff, bump_in;
   rsp_word_type      rsp_ff, rsp_in;
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_addr;
   logic [LINK_W-1:0] ram_rd_data;
   logic              head_empty;
   logic              slot_in_range;

   assign head_empty    = (free_head_ff == EMPTY_HEAD);
   assign slot_in_range = (32'(req_data.slot_in) < 32'(SLOTS));

   always_comb begin
      free_head_in = free_head_ff;
      bump_in      = bump_ff;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_addr     = SLOT_W'(free_head_ff);
      if (cmd.pop_finish) begin
         free_head_in = (ram_rd_data > EMPTY_HEAD) ? EMPTY_HEAD : ram_rd_data;
      end
      if (cmd.accept) begin
         rsp_in = '0;
         case (req_data.operation)
            OP_GET: begin
               if (!head_empty) begin
                  rsp_in.slot_out = SLOT_FIELD_W'(free_head_ff);
                  rsp_in.ok       = 1'b1;
               end else if (bump_ff != EMPTY_HEAD) begin
                  rsp_in.slot_out = SLOT_FIELD_W'(bump_ff);
                  rsp_in.ok       = 1'b1;
                  bump_in         = bump_ff + LINK_W'(1);
               end
            end
            OP_RELEASE: begin
               if (slot_in_range) begin
                  ram_wr_en    = 1'b1;
                  ram_addr     = SLOT_W'(req_data.slot_in);
                  free_head_in = LINK_W'(req_data.slot_in);
                  rsp_in.ok    = 1'b1;
               end
            end
            OP_RESET: begin
               free_head_in = EMPTY_HEAD;
               bump_in      = '0;
               rsp_in.ok    = 1'b1;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= EMPTY_HEAD;
         bump_ff      <= '0;
      end else begin
         free_head_ff <= free_head_in;
         bump_ff      <= bump_in;
      end
      rsp_ff <= rsp_in;
   end

   fspa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (cmd.pop_start),
      .addr    (ram_addr),
      .wr_data (free_head_ff),
      .rd_data (ram_rd_data)
   );

   assign status.head_empty = head_empty;
   assign rsp_data          = rsp_ff;

   `FSPA_ASSERT_NOW(a_head_bounded, clock, reset, 1'b1, free_head_ff <= EMPTY_HEAD)
   `FSPA_ASSERT_NOW(a_bump_bounded, clock, reset, 1'b1, bump_ff <= EMPTY_HEAD)
   `FSPA_ASSERT_NEXT(a_release_sets_head, clock, reset, cmd.accept && ram_wr_en, !head_empty)

endmodule

### hw/rtl/fixed_slot_pool_allocator.sv
// Fixed slot pool allocator: LIFO free list over a next-link RAM plus a bump counter.
// Response: the result word is registered in the cycle after the request word is accepted.
// Throughput: one word per cycle while the result side keeps up; a get that pops the free list
// stalls requests in the pop state, as the new head comes from the link RAM's registered read.
// Reset: synchronous; free list empty, bump counter zero, link RAM left unwritten.
// Depends on fspa_pkg, fspa_ctrl, fspa_dp.
module fixed_slot_pool_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fspa_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fspa_pkg::rsp_word_type rsp_data
);
   import fspa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fspa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   fspa_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
